[hw/rtl/flr_pkg.sv]
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants for the failed-login rate limiter.
// ----------------------------------------------------------------------------
package flr_pkg;

   localparam int KEY_W    = 64;
   localparam int STAMP_W  = 32;
   localparam int LIMIT_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int COUNT_W  = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 96;   // addr_key, now_seconds
   localparam int RSP_DATA_W = 16;   // hit_count, allowed, pad

   // Register indexes on the control port
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 8'd1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd600;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;

   // One stored failure record
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } record_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/failed_login_rate_limiter.sv]
// ----------------------------------------------------------------------------
// failed_login_rate_limiter
// Sliding-window failure counter over a ring of recent failed-login records.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                          Contents
//  req      in   req_tvalid/tready/tdata/tuser    addr_key, now_seconds; flag
//  rsp      out  rsp_tvalid/tready/tdata          hit_count, allowed
//  csr      in   csr_valid/ready/index/data       fail_limit, window_seconds
//
//  Each item walks the ring newest to oldest, checking all records in the ring
//  after the optional insert, or up to and including the first stale one; an
//  empty ring skips the walk. The single read port of the ring checks one
//  record per cycle.
//  Reset is synchronous and clears pointer, fill count, registers and control;
//  ring contents are not cleared, only filled slots are ever read.
//  The result register frees the input side: a new item is taken while the
//  previous result still waits; a finished item holds until that result is read.
// ----------------------------------------------------------------------------
module failed_login_rate_limiter #(
   parameter int RING_DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = addr_key[63:0], now_seconds[95:64]; tuser = record_failure
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [flr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   // response: tdata = hit_count[7:0], allowed[8], zero[15:9]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [flr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // control register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [flr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import flr_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]  fail_limit_ff, fail_limit_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic [PTR_W-1:0]    raddr_ff, raddr_in;
   logic [CNT_W-1:0]    issue_left_ff, issue_left_in;
   logic [CNT_W-1:0]    chk_left_ff, chk_left_in;
   logic                rvld_ff, rvld_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_allowed_ff, rsp_allowed_in;

   logic                req_xfer, rsp_xfer, csr_xfer;
   logic                rec_in;
   logic [PTR_W-1:0]    wptr_next;
   logic [CNT_W-1:0]    fill_next;
   logic                rd_issue;
   logic                stale, key_hit, walk_end;
   logic [STAMP_W:0]    stamp_limit;
   record_type          wr_rec, rd_rec;

   assign req_xfer  = req_tvalid & req_tready;
   assign rsp_xfer  = rsp_valid_ff & rsp_tready;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid & csr_ready;
   assign rec_in    = req_tuser;

   // Pointer and fill count after an optional insert
   always_comb begin
      wptr_next = wptr_ff;
      fill_next = fill_ff;
      if (rec_in) begin
         wptr_next = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
         if (fill_ff != CNT_FULL) begin
            fill_next = fill_ff + 1'b1;
         end
      end
   end

   assign wr_rec.key   = req_tdata[KEY_W-1:0];
   assign wr_rec.stamp = req_tdata[KEY_W +: STAMP_W];

   flr_ring #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_xfer & rec_in),
      .wr_addr (wptr_next),
      .wr_data (wr_rec),
      .rd_en   (rd_issue),
      .rd_addr (raddr_ff),
      .rd_data (rd_rec)
   );

   // Record check: stale when stamp + window < now, no wrap
   assign stamp_limit = {1'b0, rd_rec.stamp} + {{(STAMP_W + 1 - WINDOW_W){1'b0}}, window_ff};
   assign stale    = stamp_limit < {1'b0, now_ff};
   assign key_hit  = rd_rec.key == key_ff;
   assign walk_end = rvld_ff & (stale | (chk_left_ff == CNT_W'(1)));
   assign rd_issue = (state_ff == ST_WALK) & (issue_left_ff != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (fill_next == '0) ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      wptr_in        = wptr_ff;
      fill_in        = fill_ff;
      key_in         = key_ff;
      now_in         = now_ff;
      raddr_in       = raddr_ff;
      issue_left_in  = issue_left_ff;
      chk_left_in    = chk_left_ff;
      rvld_in        = rd_issue;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_count_in   = rsp_count_ff;
      rsp_allowed_in = rsp_allowed_ff;
      fail_limit_in  = fail_limit_ff;
      window_in      = window_ff;

      // control register writes
      if (csr_xfer) begin
         case (csr_index)
            CSR_FAIL_LIMIT: fail_limit_in = csr_data[LIMIT_W-1:0];
            CSR_WINDOW:     window_in     = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               wptr_in       = wptr_next;
               fill_in       = fill_next;
               key_in        = req_tdata[KEY_W-1:0];
               now_in        = req_tdata[KEY_W +: STAMP_W];
               raddr_in      = wptr_next;
               issue_left_in = fill_next;
               chk_left_in   = fill_next;
               count_in      = '0;
            end
         end
         ST_WALK: begin
            // one read issued per cycle, newest to oldest
            if (rd_issue) begin
               raddr_in      = (raddr_ff == '0) ? PTR_LAST : raddr_ff - 1'b1;
               issue_left_in = issue_left_ff - 1'b1;
            end
            // check the record read last cycle
            if (rvld_ff) begin
               chk_left_in = chk_left_ff - 1'b1;
               if (!stale && key_hit && count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = count_ff;
               rsp_allowed_in = (fail_limit_ff == '0) || (count_ff < fail_limit_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W - 1){1'b0}}, rsp_allowed_ff, rsp_count_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wptr_ff       <= '0;
         fill_ff       <= '0;
         rvld_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fail_limit_ff <= '0;
         window_ff     <= WINDOW_RESET;
      end else begin
         state_ff      <= state_in;
         wptr_ff       <= wptr_in;
         fill_ff       <= fill_in;
         rvld_ff       <= rvld_in;
         rsp_valid_ff  <= rsp_valid_in;
         fail_limit_ff <= fail_limit_in;
         window_ff     <= window_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      now_ff         <= now_in;
      raddr_ff       <= raddr_in;
      issue_left_ff  <= issue_left_in;
      chk_left_ff    <= chk_left_in;
      count_ff       <= count_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_allowed_ff <= rsp_allowed_in;
   end

endmodule

[hw/rtl/flr_ring.sv]
// ----------------------------------------------------------------------------
// flr_ring
// Record ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flr_ring #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  flr_pkg::record_type   wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output flr_pkg::record_type   rd_data
);
   import flr_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the failed-login rate limiter. Login attempts go in
// over the request stream in random bursts. A bench-side copy of the failure
// ring predicts each verdict, and the bench checks every verdict against it in
// order. Limit and window settings change between drained phases. The sweep
// covers limit off/one/max, and a window of zero, one, max and mid values.
// ----------------------------------------------------------------------------
module testbench;
   import flr_pkg::*;

   localparam int RING_DEPTH = 128;
   localparam int N_RANDOM   = 1000;
   localparam int N_PHASES   = 8;
   localparam int IDLE_LIMIT = 4000;              // many full-ring walks plus stalls
   localparam int SETTLE     = RING_DEPTH + 16;   // one full walk and margin

   // Register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = CSR_WINDOW + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = '1;

   typedef struct packed {
      logic               record_failure;
      logic [KEY_W-1:0]   addr_key;
      logic [STAMP_W-1:0] now_seconds;
   } attempt_type;

   typedef struct packed {
      logic [COUNT_W-1:0] hit_count;
      logic               allowed;
   } verdict_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_BLOCKED
   } rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // addr_key, now_seconds
   logic                  req_tuser  = 1'b0; // record_failure
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // hit_count, allowed, pad
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Bench copy of the failure ring and the registers
   logic [KEY_W-1:0]      ring_keys   [RING_DEPTH];
   logic [STAMP_W-1:0]    ring_stamps [RING_DEPTH];
   int                    ring_head  = 0;
   int                    ring_fill  = 0;
   logic [LIMIT_W-1:0]    limit_cfg  = '0;
   logic [WINDOW_W-1:0]   window_cfg = WINDOW_RESET;

   attempt_type           attempt_q[$];
   verdict_type           verdict_q[$];
   attempt_type           cur_attempt;
   verdict_type           due_verdict;
   verdict_type           got_verdict;

   int                    n_accepted  = 0;
   int                    n_checked   = 0;
   int                    n_blocked   = 0;
   int                    n_mismatch  = 0;
   int                    n_writes    = 0;
   int                    burst_left  = 1;
   int                    gap_left    = 0;
   int                    idle_cycles = 0;
   int unsigned           cyc         = 0;
   rx_mode_type           rx_mode     = RX_OPEN;

   failed_login_rate_limiter #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #1 clock = ~clock;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Optional insert, then count matching keys newest first until a stale stamp
   function automatic verdict_type judge_attempt(input attempt_type a);
      verdict_type v;
      int          n;
      int          slot;
      if (a.record_failure) begin
         ring_head = (ring_head + 1) % RING_DEPTH;
         if (ring_fill < RING_DEPTH) ring_fill++;
         ring_keys[ring_head]   = a.addr_key;
         ring_stamps[ring_head] = a.now_seconds;
      end
      v.hit_count = '0;
      for (n = 0; n < ring_fill; n++) begin
         slot = (ring_head + RING_DEPTH - n) % RING_DEPTH;
         // 33-bit sum so a stamp near the top of the range never wraps
         if ({1'b0, ring_stamps[slot]} + 33'(window_cfg) < {1'b0, a.now_seconds}) break;
         if (ring_keys[slot] == a.addr_key && v.hit_count != COUNT_MAX)
            v.hit_count = v.hit_count + 1'b1;
      end
      v.allowed = (limit_cfg == '0) || (v.hit_count < limit_cfg);
      return v;
   endfunction

   function automatic void flag_mismatch(input string what);
      n_mismatch++;
      if (n_mismatch <= 10) $display("MISMATCH %0d: %s", n_mismatch, what);
   endfunction

   function automatic void queue_attempt(input logic rec, input logic [KEY_W-1:0] key,
                                         input logic [STAMP_W-1:0] now);
      attempt_q.push_back('{rec, key, now});
   endfunction

   // Request driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(judge_attempt(cur_attempt));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (attempt_q.size() > 0) begin
               cur_attempt = attempt_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_attempt.now_seconds, cur_attempt.addr_key};
               req_tuser  <= cur_attempt.record_failure;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: stall pattern picked at random from time to time, then check transfers
   always @(posedge clock) begin
      cyc++;
      if (cyc % 128 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
         default:   rsp_tready <= (cyc % 16) < 5;
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_verdict.hit_count = rsp_tdata[COUNT_W-1:0];
         got_verdict.allowed   = rsp_tdata[COUNT_W];
         if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("verdict with no attempt pending: expected none, got count %0d allowed %0b",
                                    got_verdict.hit_count, got_verdict.allowed));
         end else begin
            due_verdict = verdict_q.pop_front();
            if (got_verdict.hit_count !== due_verdict.hit_count)
               flag_mismatch($sformatf("verdict %0d hit_count expected %0d got %0d",
                                       n_checked, due_verdict.hit_count,
                                       got_verdict.hit_count));
            if (got_verdict.allowed !== due_verdict.allowed)
               flag_mismatch($sformatf("verdict %0d allowed expected %0b got %0b",
                                       n_checked, due_verdict.allowed, got_verdict.allowed));
         end
         n_checked++;
         if (!got_verdict.allowed) n_blocked++;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("failed_login_rate_limiter verification failed");
         $finish;
      end
   end

   // Register write; entered and left at a rising edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FAIL_LIMIT)
         limit_cfg = value[LIMIT_W-1:0];
      else if (idx == CSR_WINDOW)
         window_cfg = value[WINDOW_W-1:0];
      n_writes++;
      @(posedge clock);
   endtask

   // Wait until every queued attempt is taken and every verdict is back
   task automatic drain();
      while (attempt_q.size() != 0 || req_tvalid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [KEY_W-1:0]    hot_keys [4];
      logic [KEY_W-1:0]    key;
      logic [LIMIT_W-1:0]  lim;
      logic [WINDOW_W-1:0] win;
      longint              wall;
      int                  phase;
      int                  k;
      int                  roll;

      hot_keys[0] = '0;
      hot_keys[1] = '1;
      hot_keys[2] = {$urandom, $urandom};
      hot_keys[3] = {$urandom, $urandom};
      while (reset) @(posedge clock);
      @(posedge clock);

      // Reset settings: limit off, 600 s window
      queue_attempt(1'b0, hot_keys[0], 32'd0);        // empty ring
      repeat (3) queue_attempt(1'b1, hot_keys[2], 32'd5);
      queue_attempt(1'b0, hot_keys[2], 32'd605);      // exactly at window edge
      queue_attempt(1'b0, hot_keys[2], 32'd606);      // one past: newest is stale
      queue_attempt(1'b1, hot_keys[1], 32'd1000);
      queue_attempt(1'b0, hot_keys[2], 32'd100);      // clock went backwards
      drain();

      // Limit two with wide data, zero window, writes to unmapped indexes
      write_reg(CSR_FAIL_LIMIT, 16'hA502);
      write_reg(CSR_WINDOW, '0);
      write_reg(CSR_UNMAPPED_LO, '1);
      write_reg(CSR_UNMAPPED_HI, 16'h1234);
      queue_attempt(1'b1, hot_keys[3], 32'd2000);
      queue_attempt(1'b1, hot_keys[3], 32'd2000);     // reaches the limit
      queue_attempt(1'b0, hot_keys[3], 32'd2000);     // stamped now still counts
      queue_attempt(1'b0, hot_keys[3], 32'd2001);     // zero window: stale
      drain();

      // Limit one, widest window, top of the time range
      write_reg(CSR_FAIL_LIMIT, 16'd1);
      write_reg(CSR_WINDOW, '1);
      queue_attempt(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
      queue_attempt(1'b1, 64'h5555_5555_5555_5555, 32'hFFFF_FFFF);
      queue_attempt(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
      queue_attempt(1'b0, 64'h5555_5555_5555_5555, 32'd0);
      drain();

      write_reg(CSR_FAIL_LIMIT, {8'h00, COUNT_MAX});
      queue_attempt(1'b1, hot_keys[1], 32'hFFFF_FFFF);
      queue_attempt(1'b0, hot_keys[1], 32'hFFFF_FFFF);
      drain();

      // Random phases: hot keys repeat so counts build up against the limit
      for (phase = 0; phase < N_PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0:       lim = '0;
            1:       lim = 8'd1;
            2:       lim = COUNT_MAX;
            default: lim = 8'($urandom_range(2, 12));
         endcase
         case (phase)
            0:       win = 16'd1;
            1:       win = '1;
            2:       win = '0;
            default: win = 16'($urandom_range(1, 400));
         endcase
         write_reg(CSR_FAIL_LIMIT, {8'($urandom), lim});
         write_reg(CSR_WINDOW, win);
         wall = (phase == 1) ? 64'hFFFE_0000 : longint'($urandom_range(0, 32'h7FFF_FFFF));
         for (k = 0; k < N_RANDOM / N_PHASES; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
               wall = (wall > 50) ? wall - $urandom_range(1, 50) : 0;
            else if (roll < 12)
               wall = wall + win + $urandom_range(1, 100);
            else
               wall = wall + $urandom_range(0, win / 8 + 1);
            if (wall > 64'hFFFF_FFFF) wall = 64'hFFFF_FFFF;
            key = ($urandom_range(0, 99) < 85) ? hot_keys[2'($urandom_range(0, 3))]
                                               : {$urandom, $urandom};
            queue_attempt($urandom_range(0, 99) < 65, key, wall[STAMP_W-1:0]);
         end
         drain();
      end

      $display("Summary: %0d login attempts over %0d register writes, %0d verdicts checked",
               n_accepted, n_writes, n_checked);
      $display("Summary: %0d verdicts blocked, ring held %0d failures at the end",
               n_blocked, ring_fill);
      if (n_mismatch == 0)
         $display("failed_login_rate_limiter verification clean");
      else
         $display("failed_login_rate_limiter verification failed");
      $finish;
   end

endmodule
